[rtl/refcounted_lru_entry_cache_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the entry cache checker.
// The macros expect a signal named clock, and all but LRC_ASSERT_NEXT_ALWAYS
// one named reset, in the using scope.
`ifndef REFCOUNTED_LRU_ENTRY_CACHE_CORE_MACROS_SVH
`define REFCOUNTED_LRU_ENTRY_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LRC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("entry cache check failed");

// Next-cycle implication, disabled during reset.
`define LRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("entry cache check failed");

// Next-cycle implication that also holds across reset.
`define LRC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("entry cache reset check failed");

`endif

[rtl/lrc_pkg.sv]
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared constants and types of the reference-counted LRU cache.
// ----------------------------------------------------------------------------
package lrc_pkg;

   localparam int CAPACITY   = 16;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 32;
   localparam int USE_W      = 16;
   localparam int KEEP_W     = 5;
   localparam int STATUS_W   = 3;
   localparam int OP_W       = 2;
   localparam int HANDLE_W   = 4;
   localparam int SLOT_OUT_W = 4;
   localparam int EV_W       = 5;
   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(4);
   localparam logic [USE_W-1:0]  USE_MAX    = {USE_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP  = 2'd0,
      OP_ADD     = 2'd1,
      OP_RELEASE = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT         = 3'd0,
      ST_INSERTED    = 3'd1,
      ST_LOAD_FAILED = 3'd2,
      ST_FULL        = 3'd3,
      ST_RELEASED    = 3'd4,
      ST_BAD_HANDLE  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_NEXT,
      S_DONE
   } state_type;

   // Kind of sweep that the sequencer runs over the table.
   typedef enum logic [2:0] {
      P_LOOKUP,
      P_HIT_ADJ,
      P_ADD_ADJ,
      P_COUNT,
      P_FIND,
      P_DROP
   } pass_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              named;
      logic [USE_W-1:0]  use_cnt;
      logic [SLOT_W-1:0] rank;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] raddr;
      logic              we;
      logic [SLOT_W-1:0] waddr;
      entry_type         wdata;
   } mem_req_type;

endpackage

[rtl/lrc_ram.sv]
// ----------------------------------------------------------------------------
// lrc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/lrc_ctrl.sv]
// ----------------------------------------------------------------------------
// lrc_ctrl
// Sequencer of the cache: sweeps the entry RAM one slot per cycle, reads,
// modifies and writes back entries, and holds the result register.
// ----------------------------------------------------------------------------
module lrc_ctrl import lrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [KEY_W-1:0]      req_key,
   input  logic                  req_load_ok,
   input  logic [HANDLE_W-1:0]   req_handle,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [USE_W-1:0]      rsp_use_after,
   output logic [EV_W-1:0]       rsp_evicted,
   input  logic                  csr_we,
   input  logic [KEEP_W-1:0]     csr_wdata,
   output mem_req_type           mem_req,
   input  entry_type             mem_rdata
);

   state_type             state_ff, state_in;
   pass_type              pass_ff, pass_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic                  load_ok_ff, load_ok_in;
   logic [SLOT_W-1:0]     hslot_ff, hslot_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [KEEP_W-1:0]     keep_ff, keep_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     tgt_slot_ff, tgt_slot_in;
   logic [SLOT_W-1:0]     tgt_rank_ff, tgt_rank_in;
   logic [USE_W-1:0]      tgt_use_ff, tgt_use_in;
   logic [CNT_W-1:0]      unused_ff, unused_in;
   logic [CNT_W-1:0]      ev_ff, ev_in;
   status_type            res_status_ff, res_status_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [USE_W-1:0]      res_use_ff, res_use_in;
   logic [CNT_W-1:0]      res_ev_ff, res_ev_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [USE_W-1:0]      rsp_use_ff, rsp_use_in;
   logic [CNT_W-1:0]      rsp_ev_ff, rsp_ev_in;

   logic                  free_any;
   logic [SLOT_W-1:0]     free_slot;
   logic [SLOT_W-1:0]     proc_slot;
   logic                  proc_valid;
   logic [USE_W-1:0]      cnt_use;
   logic [CNT_W-1:0]      unused_now;

   // Lowest-numbered free slot.
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   // Slot whose read data arrives in this cycle.
   assign proc_slot  = SLOT_W'(idx_ff - CNT_W'(1));
   assign proc_valid = valid_ff[proc_slot];

   // Next state, sweep processing and memory requests.
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      load_ok_in    = load_ok_ff;
      hslot_in      = hslot_ff;
      valid_in      = valid_ff;
      total_in      = total_ff;
      keep_in       = keep_ff;
      found_in      = found_ff;
      tgt_slot_in   = tgt_slot_ff;
      tgt_rank_in   = tgt_rank_ff;
      tgt_use_in    = tgt_use_ff;
      unused_in     = unused_ff;
      ev_in         = ev_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_use_in    = res_use_ff;
      res_ev_in     = res_ev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_use_in    = rsp_use_ff;
      rsp_ev_in     = rsp_ev_ff;
      mem_req       = '0;
      cnt_use       = '0;
      unused_now    = unused_ff;
      req_ready     = (state_ff == S_IDLE);

      if (csr_we) begin
         keep_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in      = req_key;
               load_ok_in  = req_load_ok;
               hslot_in    = SLOT_W'(req_handle);
               found_in    = 1'b0;
               idx_in      = '0;
               unused_in   = '0;
               ev_in       = '0;
               res_slot_in = '0;
               res_use_in  = '0;
               res_ev_in   = '0;
               case (req_opcode)
                  OP_LOOKUP: begin
                     pass_in  = P_LOOKUP;
                     state_in = S_SCAN;
                  end
                  OP_ADD: begin
                     if (!req_load_ok) begin
                        res_status_in = ST_LOAD_FAILED;
                        state_in      = S_DONE;
                     end else if (!free_any) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        pass_in  = P_ADD_ADJ;
                        state_in = S_SCAN;
                     end
                  end
                  OP_RELEASE: begin
                     if ((32'(req_handle) < CAPACITY) &&
                         valid_ff[SLOT_W'(req_handle)]) begin
                        pass_in  = P_COUNT;
                        state_in = S_SCAN;
                     end else begin
                        res_status_in = ST_BAD_HANDLE;
                        state_in      = S_DONE;
                     end
                  end
                  default: begin
                     res_status_in = ST_BAD_HANDLE;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue the read of the next slot.
            if (idx_ff < CNT_W'(CAPACITY)) begin
               mem_req.rd_en = 1'b1;
               mem_req.raddr = idx_ff[SLOT_W-1:0];
            end
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(CAPACITY)) begin
               idx_in   = '0;
               state_in = S_NEXT;
            end
            // Work on the slot whose data came back.
            if (idx_ff != '0 && proc_valid) begin
               mem_req.waddr = proc_slot;
               mem_req.wdata = mem_rdata;
               case (pass_ff)
                  P_LOOKUP: begin
                     if (mem_rdata.named && mem_rdata.key == key_ff && !found_ff) begin
                        found_in    = 1'b1;
                        tgt_slot_in = proc_slot;
                        tgt_rank_in = mem_rdata.rank;
                        tgt_use_in  = (mem_rdata.use_cnt == USE_MAX) ? USE_MAX :
                                      mem_rdata.use_cnt + USE_W'(1);
                     end
                  end
                  P_HIT_ADJ: begin
                     if (proc_slot == tgt_slot_ff) begin
                        mem_req.we            = 1'b1;
                        mem_req.wdata.use_cnt = tgt_use_ff;
                        mem_req.wdata.rank    = SLOT_W'(total_ff - CNT_W'(1));
                     end else if (mem_rdata.rank > tgt_rank_ff) begin
                        mem_req.we         = 1'b1;
                        mem_req.wdata.rank = mem_rdata.rank - SLOT_W'(1);
                     end
                  end
                  P_ADD_ADJ: begin
                     mem_req.we         = 1'b1;
                     mem_req.wdata.rank = mem_rdata.rank + SLOT_W'(1);
                  end
                  P_COUNT: begin
                     cnt_use = mem_rdata.use_cnt;
                     if (proc_slot == hslot_ff) begin
                        if (mem_rdata.use_cnt != '0) begin
                           cnt_use = mem_rdata.use_cnt - USE_W'(1);
                        end
                        mem_req.we            = 1'b1;
                        mem_req.wdata.use_cnt = cnt_use;
                        tgt_use_in            = cnt_use;
                     end
                     if (cnt_use == '0) begin
                        unused_in = unused_ff + CNT_W'(1);
                     end
                  end
                  P_FIND: begin
                     if (mem_rdata.use_cnt == '0 &&
                         (!found_ff || mem_rdata.rank < tgt_rank_ff)) begin
                        found_in    = 1'b1;
                        tgt_slot_in = proc_slot;
                        tgt_rank_in = mem_rdata.rank;
                     end
                  end
                  P_DROP: begin
                     if (proc_slot != tgt_slot_ff && mem_rdata.rank > tgt_rank_ff) begin
                        mem_req.we         = 1'b1;
                        mem_req.wdata.rank = mem_rdata.rank - SLOT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_NEXT: begin
            state_in = S_DONE;
            case (pass_ff)
               P_LOOKUP: begin
                  if (found_ff) begin
                     pass_in  = P_HIT_ADJ;
                     state_in = S_SCAN;
                  end else if (!load_ok_ff) begin
                     res_status_in = ST_LOAD_FAILED;
                  end else if (!free_any) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_req.we            = 1'b1;
                     mem_req.waddr         = free_slot;
                     mem_req.wdata.key     = key_ff;
                     mem_req.wdata.named   = 1'b1;
                     mem_req.wdata.use_cnt = USE_W'(1);
                     mem_req.wdata.rank    = SLOT_W'(total_ff);
                     valid_in[free_slot]   = 1'b1;
                     total_in              = total_ff + CNT_W'(1);
                     res_status_in         = ST_INSERTED;
                     res_slot_in           = free_slot;
                     res_use_in            = USE_W'(1);
                  end
               end
               P_HIT_ADJ: begin
                  res_status_in = ST_HIT;
                  res_slot_in   = tgt_slot_ff;
                  res_use_in    = tgt_use_ff;
               end
               P_ADD_ADJ: begin
                  mem_req.we            = 1'b1;
                  mem_req.waddr         = free_slot;
                  mem_req.wdata.key     = '0;
                  mem_req.wdata.named   = 1'b0;
                  mem_req.wdata.use_cnt = USE_W'(1);
                  mem_req.wdata.rank    = '0;
                  valid_in[free_slot]   = 1'b1;
                  total_in              = total_ff + CNT_W'(1);
                  res_status_in         = ST_INSERTED;
                  res_slot_in           = free_slot;
                  res_use_in            = USE_W'(1);
               end
               P_FIND: begin
                  if (found_ff) begin
                     pass_in  = P_DROP;
                     state_in = S_SCAN;
                  end else begin
                     res_status_in = ST_RELEASED;
                     res_slot_in   = hslot_ff;
                     res_use_in    = tgt_use_ff;
                     res_ev_in     = ev_ff;
                  end
               end
               default: begin
                  // Count sweep or a finished drop: evict while too many unused.
                  if (pass_ff == P_DROP) begin
                     valid_in[tgt_slot_ff] = 1'b0;
                     total_in              = total_ff - CNT_W'(1);
                     unused_now            = unused_ff - CNT_W'(1);
                     ev_in                 = ev_ff + CNT_W'(1);
                     unused_in             = unused_now;
                  end
                  if (32'(unused_now) > 32'(keep_ff)) begin
                     found_in = 1'b0;
                     pass_in  = P_FIND;
                     state_in = S_SCAN;
                  end else begin
                     res_status_in = ST_RELEASED;
                     res_slot_in   = hslot_ff;
                     res_use_in    = tgt_use_ff;
                     res_ev_in     = ev_in;
                  end
               end
            endcase
         end

         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_use_in    = res_use_ff;
               rsp_ev_in     = res_ev_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         keep_ff      <= KEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      pass_ff       <= pass_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      load_ok_ff    <= load_ok_in;
      hslot_ff      <= hslot_in;
      found_ff      <= found_in;
      tgt_slot_ff   <= tgt_slot_in;
      tgt_rank_ff   <= tgt_rank_in;
      tgt_use_ff    <= tgt_use_in;
      unused_ff     <= unused_in;
      ev_ff         <= ev_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_use_ff    <= res_use_in;
      res_ev_ff     <= res_ev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_use_ff    <= rsp_use_in;
      rsp_ev_ff     <= rsp_ev_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_use_after = rsp_use_ff;
   assign rsp_evicted   = EV_W'(rsp_ev_ff);

endmodule

[rtl/refcounted_lru_entry_cache_core.sv]
// ----------------------------------------------------------------------------
// refcounted_lru_entry_cache_core
// Reference-counted cache table of 16 entries kept in recency order.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the req_ valid/ready channel (opcode, key, load_ok,
//   handle) and each gives exactly one result on the rsp_ channel (status,
//   slot, use_after, evicted). csr_we writes keep_unused; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Entries live in a one-port-read, one-port-write RAM; the sequencer sweeps
//   it one slot per cycle, and each sweep ends in a decision state. An add
//   takes one sweep, a lookup one or two sweeps, a release one count sweep
//   plus two sweeps per evicted entry. A failed add, a bad handle and an
//   unused opcode finish without a sweep; a lookup that fails or finds the
//   table full still takes a sweep. One item is processed at a time; the
//   next item is taken once the result has moved to the output register,
//   even while that result still waits. Reset empties the table and sets
//   keep_unused to 4; RAM contents are left as they are, since valid bits
//   gate every read. A stalled receiver holds the result and, after one
//   more finished item, holds off new items.
// ----------------------------------------------------------------------------
module refcounted_lru_entry_cache_core import lrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [KEY_W-1:0]      req_key,
   input  logic                  req_load_ok,
   input  logic [HANDLE_W-1:0]   req_handle,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [USE_W-1:0]      rsp_use_after,
   output logic [EV_W-1:0]       rsp_evicted,
   input  logic                  csr_we,
   input  logic [KEEP_W-1:0]     csr_wdata
);

   mem_req_type mem_req;
   entry_type   mem_rdata;
   logic [ENTRY_W-1:0] ram_rdata;

   // Entry storage.
   lrc_ram #(
      .DEPTH(CAPACITY),
      .WIDTH(ENTRY_W)
   ) u_ram (
      .clock (clock),
      .rd_en (mem_req.rd_en),
      .raddr (mem_req.raddr),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .rdata (ram_rdata)
   );

   assign mem_rdata = entry_type'(ram_rdata);

   // Sweep sequencer and result register.
   lrc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_key       (req_key),
      .req_load_ok   (req_load_ok),
      .req_handle    (req_handle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_use_after (rsp_use_after),
      .rsp_evicted   (rsp_evicted),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mem_req       (mem_req),
      .mem_rdata     (mem_rdata)
   );

endmodule

[rtl/lrc_checker.sv]
// ----------------------------------------------------------------------------
// lrc_checker
// Port-level checks of the entry cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcounted_lru_entry_cache_core_macros.svh"

module lrc_checker import lrc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [SLOT_OUT_W-1:0] rsp_slot,
   input logic [USE_W-1:0]      rsp_use_after,
   input logic [EV_W-1:0]       rsp_evicted
);

   // A stalled result stays offered.
   `LRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // No result right after reset.
   `LRC_ASSERT_NEXT_ALWAYS(a_reset_clear, reset, !rsp_valid)

   // Only a release reports evictions.
   `LRC_ASSERT_NOW(a_ev_release, rsp_valid && rsp_status != ST_RELEASED, rsp_evicted == '0)

   // A fresh entry always starts with one user.
   `LRC_ASSERT_NOW(a_insert_use, rsp_valid && rsp_status == ST_INSERTED, rsp_use_after == 16'd1)

   // Rejected items carry no slot and no count.
   `LRC_ASSERT_NOW(a_reject_zero,
      rsp_valid && (rsp_status == ST_BAD_HANDLE || rsp_status == ST_FULL ||
      rsp_status == ST_LOAD_FAILED), rsp_slot == '0 && rsp_use_after == '0)

endmodule

bind refcounted_lru_entry_cache_core lrc_checker u_lrc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_slot      (rsp_slot),
   .rsp_use_after (rsp_use_after),
   .rsp_evicted   (rsp_evicted)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reference-counted LRU entry cache. Items go in
// on the req_ channel with bursty gaps; a predictor of the table computes the
// expected result of each item, and results are compared field by field while
// the receiver stalls on its own pattern. keep_unused is changed between phases.
// ----------------------------------------------------------------------------
module tb;
   import lrc_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [KEY_W-1:0]    key;
      logic                load_ok;
      logic [HANDLE_W-1:0] handle;
   } cache_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [USE_W-1:0]      use_after;
      logic [EV_W-1:0]       evicted;
   } cache_rsp_type;

   // Directed row: item, with optional typed-in expectation.
   typedef struct {
      cache_op_type  op;
      logic          has_exp;
      cache_rsp_type exp;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_opcode;
   logic [KEY_W-1:0]      req_key;
   logic                  req_load_ok;
   logic [HANDLE_W-1:0]   req_handle;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic [USE_W-1:0]      rsp_use_after;
   logic [EV_W-1:0]       rsp_evicted;
   logic                  csr_we;
   logic [KEEP_W-1:0]     csr_wdata;

   // Predictor copy of the table.
   logic [KEY_W-1:0]  tbl_key   [CAPACITY];
   logic              tbl_valid [CAPACITY];
   logic              tbl_named [CAPACITY];
   logic [USE_W-1:0]  tbl_use   [CAPACITY];
   int                tbl_rank  [CAPACITY];
   int                tbl_total;
   int                keep_limit;

   cache_rsp_type pending_rsp[$];
   int            error_count;
   int            rsp_count;
   int            item_count;
   int            evict_total;
   logic [KEY_W-1:0] key_pool[8];

   refcounted_lru_entry_cache_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_key       (req_key),
      .req_load_ok   (req_load_ok),
      .req_handle    (req_handle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_use_after (rsp_use_after),
      .rsp_evicted   (rsp_evicted),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("tb: failure");
      $finish;
   end

   function automatic cache_rsp_type make_rsp(int st, int sl, int u, int ev);
      cache_rsp_type r;
      r.status    = STATUS_W'(st);
      r.slot      = SLOT_OUT_W'(sl);
      r.use_after = USE_W'(u);
      r.evicted   = EV_W'(ev);
      return r;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < CAPACITY; i++) begin
         tbl_key[i]   = '0;
         tbl_valid[i] = 1'b0;
         tbl_named[i] = 1'b0;
         tbl_use[i]   = '0;
         tbl_rank[i]  = 0;
      end
      tbl_total = 0;
   endfunction

   function automatic int lowest_free_slot();
      for (int i = 0; i < CAPACITY; i++)
         if (!tbl_valid[i]) return i;
      return -1;
   endfunction

   // Remove a slot from the recency order.
   function automatic void evict_slot(int s);
      for (int i = 0; i < CAPACITY; i++)
         if (tbl_valid[i] && i != s && tbl_rank[i] > tbl_rank[s]) tbl_rank[i]--;
      tbl_valid[s] = 1'b0;
      tbl_named[s] = 1'b0;
      tbl_use[s]   = '0;
      tbl_rank[s]  = 0;
      if (tbl_total > 0) tbl_total--;
   endfunction

   // Apply one item to the predicted table and return its result.
   function automatic cache_rsp_type cache_apply(cache_op_type op);
      int s;
      int unused;
      int ev;
      int best;
      logic [USE_W-1:0] u;
      if (op.opcode == OP_LOOKUP) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (tbl_valid[i] && tbl_named[i] && tbl_key[i] == op.key) begin
               for (int j = 0; j < CAPACITY; j++)
                  if (tbl_valid[j] && j != i && tbl_rank[j] > tbl_rank[i]) tbl_rank[j]--;
               tbl_rank[i] = tbl_total - 1;
               if (tbl_use[i] != USE_MAX) tbl_use[i]++;
               return make_rsp(ST_HIT, i, tbl_use[i], 0);
            end
         end
         if (!op.load_ok) return make_rsp(ST_LOAD_FAILED, 0, 0, 0);
         s = lowest_free_slot();
         if (s < 0) return make_rsp(ST_FULL, 0, 0, 0);
         tbl_key[s] = op.key;
         tbl_valid[s] = 1'b1;
         tbl_named[s] = 1'b1;
         tbl_use[s] = USE_W'(1);
         tbl_rank[s] = tbl_total;
         tbl_total++;
         return make_rsp(ST_INSERTED, s, 1, 0);
      end
      if (op.opcode == OP_ADD) begin
         if (!op.load_ok) return make_rsp(ST_LOAD_FAILED, 0, 0, 0);
         s = lowest_free_slot();
         if (s < 0) return make_rsp(ST_FULL, 0, 0, 0);
         for (int i = 0; i < CAPACITY; i++)
            if (tbl_valid[i]) tbl_rank[i]++;
         tbl_key[s] = '0;
         tbl_valid[s] = 1'b1;
         tbl_named[s] = 1'b0;
         tbl_use[s] = USE_W'(1);
         tbl_rank[s] = 0;
         tbl_total++;
         return make_rsp(ST_INSERTED, s, 1, 0);
      end
      if (op.opcode == OP_RELEASE && tbl_valid[op.handle]) begin
         if (tbl_use[op.handle] != 0) tbl_use[op.handle]--;
         u = tbl_use[op.handle];
         unused = 0;
         ev = 0;
         for (int i = 0; i < CAPACITY; i++)
            if (tbl_valid[i] && tbl_use[i] == 0) unused++;
         while (unused > keep_limit) begin
            best = -1;
            for (int i = 0; i < CAPACITY; i++)
               if (tbl_valid[i] && tbl_use[i] == 0 &&
                   (best < 0 || tbl_rank[i] < tbl_rank[best])) best = i;
            if (best < 0) break;
            evict_slot(best);
            unused--;
            ev++;
         end
         evict_total += ev;
         return make_rsp(ST_RELEASED, op.handle, u, ev);
      end
      return make_rsp(ST_BAD_HANDLE, 0, 0, 0);
   endfunction

   // Drive one item, wait for its acceptance, and queue the expectation.
   task automatic send_item(cache_op_type op, logic has_exp, cache_rsp_type exp);
      cache_rsp_type pred;
      req_valid   <= 1'b1;
      req_opcode  <= op.opcode;
      req_key     <= op.key;
      req_load_ok <= op.load_ok;
      req_handle  <= op.handle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = cache_apply(op);
      if (has_exp && pred != exp)
         $display("%0t: directed row expectation %p differs from predictor %p",
                  $time, exp, pred);
      pending_rsp.push_back(has_exp ? exp : pred);
      item_count++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for all results, then let a release sweep finish.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_keep(int v);
      csr_we    <= 1'b1;
      csr_wdata <= KEEP_W'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      keep_limit = v;
   endtask

   // Random item: mostly lookups on a small key pool and releases of random handles.
   function automatic cache_op_type random_op();
      cache_op_type op;
      int pick;
      pick = $urandom_range(0, 99);
      op.key     = $urandom_range(0, 9) == 0 ? $urandom() : key_pool[$urandom_range(0, 7)];
      op.load_ok = $urandom_range(0, 7) != 0;
      op.handle  = HANDLE_W'($urandom());
      if (pick < 45)      op.opcode = OP_LOOKUP;
      else if (pick < 55) op.opcode = OP_ADD;
      else if (pick < 97) op.opcode = OP_RELEASE;
      else                op.opcode = OP_UNUSED;
      return op;
   endfunction

   // Receiver stalls in a pattern of its own; results are checked here.
   initial begin
      int phase;
      cache_rsp_type exp;
      rsp_ready <= 1'b0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result status %0d", $time, rsp_status);
               error_count++;
            end else begin
               exp = pending_rsp.pop_front();
               if (rsp_status !== exp.status || rsp_slot !== exp.slot ||
                   rsp_use_after !== exp.use_after || rsp_evicted !== exp.evicted) begin
                  $display("%0t: expected st=%0d slot=%0d use=%0d ev=%0d, got st=%0d slot=%0d use=%0d ev=%0d",
                           $time, exp.status, exp.slot, exp.use_after, exp.evicted,
                           rsp_status, rsp_slot, rsp_use_after, rsp_evicted);
                  error_count++;
               end
               rsp_count++;
            end
         end
         phase++;
         if ((phase / 500) % 3 == 2) rsp_ready <= 1'b1;
         else rsp_ready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
      end
   end

   dir_row_type dir_rows[$];

   function automatic void add_row(int opc, logic [31:0] k, logic ok, int h,
                                   logic has, int st, int sl, int u, int ev);
      dir_row_type r;
      r.op.opcode  = OP_W'(opc);
      r.op.key     = k;
      r.op.load_ok = ok;
      r.op.handle  = HANDLE_W'(h);
      r.has_exp    = has;
      r.exp        = make_rsp(st, sl, u, ev);
      dir_rows.push_back(r);
   endfunction

   initial begin
      cache_op_type op;
      int burst;
      int keep_vals[6];
      error_count = 0;
      rsp_count = 0;
      item_count = 0;
      evict_total = 0;
      req_valid <= 1'b0;
      req_opcode <= '0;
      req_key <= '0;
      req_load_ok <= 1'b0;
      req_handle <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      reset <= 1'b1;
      clear_table();
      keep_limit = KEEP_RESET;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: extremes, all opcodes and the named special cases.
      add_row(OP_RELEASE, 0, 0, 0, 1, ST_BAD_HANDLE, 0, 0, 0);
      add_row(OP_UNUSED, '1, 1, 15, 1, ST_BAD_HANDLE, 0, 0, 0);
      add_row(OP_LOOKUP, 0, 1, 0, 1, ST_INSERTED, 0, 1, 0);
      add_row(OP_LOOKUP, 0, 0, 0, 1, ST_HIT, 0, 2, 0);
      add_row(OP_LOOKUP, 32'hFFFFFFFF, 0, 0, 1, ST_LOAD_FAILED, 0, 0, 0);
      add_row(OP_LOOKUP, 32'hFFFFFFFF, 1, 15, 1, ST_INSERTED, 1, 1, 0);
      add_row(OP_ADD, '1, 0, 0, 1, ST_LOAD_FAILED, 0, 0, 0);
      add_row(OP_ADD, 32'hA5A5A5A5, 1, 0, 1, ST_INSERTED, 2, 1, 0);
      add_row(OP_LOOKUP, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(OP_RELEASE, 0, 0, 2, 1, ST_RELEASED, 2, 0, 0);
      add_row(OP_RELEASE, 0, 0, 2, 1, ST_RELEASED, 2, 0, 0);
      add_row(OP_RELEASE, 0, 0, 1, 1, ST_RELEASED, 1, 0, 0);
      add_row(OP_RELEASE, '1, 1, 9, 1, ST_BAD_HANDLE, 0, 0, 0);
      for (int i = 0; i < 14; i++) add_row(OP_ADD, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(OP_ADD, 0, 1, 0, 1, ST_FULL, 0, 0, 0);
      add_row(OP_LOOKUP, 32'h12345678, 1, 0, 1, ST_FULL, 0, 0, 0);
      foreach (dir_rows[i]) send_item(dir_rows[i].op, dir_rows[i].has_exp, dir_rows[i].exp);
      drain();

      // Keep nothing: a release of the lone-used slot flushes every unused entry.
      write_keep(0);
      op.opcode = OP_RELEASE; op.key = 0; op.load_ok = 0; op.handle = 3;
      send_item(op, 1'b0, make_rsp(0, 0, 0, 0));
      drain();

      // Random phases over several keep_unused settings, extremes included.
      keep_vals = '{16, 0, 2, 31, 4, 7};
      for (int p = 0; p < 6; p++) begin
         write_keep(keep_vals[p]);
         for (int n = 0; n < 285; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 285; b++, n++) send_item(random_op(), 1'b0, make_rsp(0, 0, 0, 0));
            if ($urandom_range(0, 2) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end
         end
         drain();
      end

      $display("Ran %0d items, %0d results checked, %0d entries evicted.",
               item_count, rsp_count, evict_total);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
